// File: hdl/c2s_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2s_pkg
// Shared widths, types and tables of the Cartesian to spherical converter.
// ----------------------------------------------------------------------------
package c2s_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int IN_W        = ((3 * COORD_WIDTH + 7) / 8) * 8;

	localparam int WORK_BITS = 40;
	localparam int SCALE_SH  = WORK_BITS - COORD_WIDTH;
	localparam int A_W       = WORK_BITS + 3;
	localparam int ACC_W     = 24;
	localparam int ANG_SH    = 8;
	localparam int ANG_W     = ACC_W - ANG_SH;
	localparam int STEPS     = 18;
	localparam int STEP_W    = 5;

	localparam logic signed [ACC_W-1:0] QUARTER_TURN = ACC_W'(90 * 32768);
	localparam logic signed [ACC_W-1:0] ANGLE_HALF   = ACC_W'(128);

	localparam int GAIN_W  = 20;
	localparam int GAIN_SH = 20;
	localparam logic [GAIN_W-1:0] INV_GAIN_Q20 = GAIN_W'(636751);

	localparam int MAG_W     = 16;
	localparam int LIM_W     = (COORD_WIDTH > 17) ? COORD_WIDTH : 17;
	localparam int SQR_W     = 2 * MAG_W;
	localparam int SQ_W      = SQR_W + 2;
	localparam int TR_W      = SQ_W + 1;
	localparam int RT_W      = 17;
	localparam int RT_IDX_W  = 5;

	localparam int RAD_W   = 16;
	localparam int POL_W   = 15;
	localparam int AZ_W    = ANG_W;
	localparam int OUT_W   = 48;
	localparam int OUT_PAD = OUT_W - RAD_W - POL_W - AZ_W;

	localparam logic [RAD_W-1:0]        RADIUS_MAX = '1;
	localparam logic signed [ANG_W-1:0] ANGLE_MAX  = ANG_W'(23040);

	typedef struct packed {
		logic signed [A_W-1:0]   a;
		logic signed [A_W-1:0]   b;
		logic signed [ACC_W-1:0] acc;
	} rot_t;

	typedef struct packed {
		logic [SQ_W-1:0] rem;
		logic [RT_W-1:0] root;
	} sq_t;

	function automatic logic signed [ACC_W-1:0] c2s_atan(input logic [STEP_W-1:0] idx);
		logic signed [ACC_W-1:0] t;
		unique case (idx)
			5'd0:    t = ACC_W'(1474560);
			5'd1:    t = ACC_W'(870484);
			5'd2:    t = ACC_W'(459940);
			5'd3:    t = ACC_W'(233473);
			5'd4:    t = ACC_W'(117189);
			5'd5:    t = ACC_W'(58652);
			5'd6:    t = ACC_W'(29333);
			5'd7:    t = ACC_W'(14667);
			5'd8:    t = ACC_W'(7334);
			5'd9:    t = ACC_W'(3667);
			5'd10:   t = ACC_W'(1833);
			5'd11:   t = ACC_W'(917);
			5'd12:   t = ACC_W'(458);
			5'd13:   t = ACC_W'(229);
			5'd14:   t = ACC_W'(115);
			5'd15:   t = ACC_W'(57);
			5'd16:   t = ACC_W'(29);
			5'd17:   t = ACC_W'(14);
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage

// File: hdl/c2s_rot_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2s_rot_cell
// One vectoring micro-rotation: turn the vector toward the x axis by
// atan(2^-step) and register the result.
// ----------------------------------------------------------------------------
module c2s_rot_cell (
	input  logic                       clk,
	input  logic                       en,
	input  logic [c2s_pkg::STEP_W-1:0] step,
	input  c2s_pkg::rot_t              rot_in,
	output c2s_pkg::rot_t              rot_out
);
	import c2s_pkg::*;

	logic signed [A_W-1:0]   a_in;
	logic signed [A_W-1:0]   b_in;
	logic signed [A_W-1:0]   da;
	logic signed [A_W-1:0]   db;
	logic signed [ACC_W-1:0] ang;
	rot_t                    nxt;
	rot_t                    rot_q;

	always_comb begin
		a_in = rot_in.a;
		b_in = rot_in.b;
		da   = b_in >>> step;
		db   = a_in >>> step;
		ang  = c2s_atan(step);
		if (b_in > 0) begin
			nxt.a   = a_in + da;
			nxt.b   = b_in - db;
			nxt.acc = rot_in.acc + ang;
		end else begin
			nxt.a   = a_in - da;
			nxt.b   = b_in + db;
			nxt.acc = rot_in.acc - ang;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_q <= nxt;
		end
	end

	assign rot_out = rot_q;

endmodule

// File: hdl/c2s_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2s_sqrt_cell
// One digit of a restoring square root: try the root bit selected by step
// against the running remainder and register the result.
// ----------------------------------------------------------------------------
module c2s_sqrt_cell (
	input  logic                         clk,
	input  logic                         en,
	input  logic [c2s_pkg::RT_IDX_W-1:0] step,
	input  c2s_pkg::sq_t                 sq_in,
	output c2s_pkg::sq_t                 sq_out
);
	import c2s_pkg::*;

	logic [RT_W-1:0] bit_v;
	logic [TR_W-1:0] trial;
	sq_t             nxt;
	sq_t             sq_q;

	always_comb begin
		bit_v = RT_W'(1) << step;
		trial = (TR_W'({sq_in.root, 1'b0}) + TR_W'(bit_v)) << step;
		nxt   = sq_in;
		if (TR_W'(sq_in.rem) >= trial) begin
			nxt.root = sq_in.root | bit_v;
			nxt.rem  = sq_in.rem - trial[SQ_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_q <= nxt;
		end
	end

	assign sq_out = sq_q;

endmodule

// File: hdl/cartesian_to_spherical_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartesian_to_spherical_core
// Converts a signed Cartesian point to radius, polar angle and azimuth.
// Two chains of rotation cells compute the angles, a chain of root-digit
// cells computes the radius.
//
//   channel  dir  fields (low bit first)
//   s_*      in   s_tdata: coord_x, coord_y, coord_z
//   m_*      out  m_tdata: radius, polar_angle, azimuth; m_tuser: zero_vector
//
// One request enters per cycle while the output is not stalled.
// The two 18-cell rotation chains and the gain multiply set the depth.
// A stalled output holds the whole pipeline; bubbles are not squeezed out.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module cartesian_to_spherical_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [c2s_pkg::IN_W-1:0] s_tdata,  // coord_x, coord_y, coord_z
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [c2s_pkg::OUT_W-1:0] m_tdata, // radius, polar_angle, azimuth
	output logic                     m_tuser   // zero_vector
);
	import c2s_pkg::*;

	localparam int CW        = COORD_WIDTH;
	localparam int ST_AZ_END = 2 + STEPS;
	localparam int ST_RES    = ST_AZ_END + 1;
	localparam int ST_PRE    = ST_RES + 2;
	localparam int ST_OUT    = ST_PRE + STEPS + 1;
	localparam int PH_W      = A_W - GAIN_SH + GAIN_W + 1;
	localparam int PL_W      = 2 * GAIN_W;

	typedef struct packed {
		logic signed [CW-1:0] z;
		logic                 zero;
		logic                 xy0;
		logic                 sat;
	} side_t;

	typedef struct packed {
		logic [RAD_W-1:0]       radius;
		logic signed [AZ_W-1:0] azimuth;
		logic                   zero;
	} res_t;

	function automatic logic signed [A_W-1:0] scale(input logic signed [CW-1:0] v);
		return {{(A_W - WORK_BITS){v[CW-1]}}, v, {SCALE_SH{1'b0}}};
	endfunction

	function automatic logic [LIM_W-1:0] mag(input logic signed [CW-1:0] v);
		logic [CW-1:0] m;
		m = v[CW-1] ? CW'(-v) : v;
		return LIM_W'(m);
	endfunction

	function automatic rot_t prerot(input logic signed [A_W-1:0] a,
	                               input logic signed [A_W-1:0] b);
		rot_t r;
		r.a   = a;
		r.b   = b;
		r.acc = '0;
		if (a < 0) begin
			if (b >= 0) begin
				r.a   = b;
				r.b   = -a;
				r.acc = QUARTER_TURN;
			end else begin
				r.a   = -b;
				r.b   = a;
				r.acc = -QUARTER_TURN;
			end
		end
		return r;
	endfunction

	function automatic logic signed [ANG_W-1:0] round_angle(
		input logic signed [ACC_W-1:0] acc);
		logic [ACC_W-1:0] sum;
		sum = acc + ANGLE_HALF;
		return sum[ACC_W-1:ANG_SH];
	endfunction

	logic                 adv;
	logic [ST_OUT:1]      vld_q;

	logic signed [CW-1:0] in_x;
	logic signed [CW-1:0] in_y;
	logic signed [CW-1:0] in_z;
	logic signed [CW-1:0] x_s1;
	logic signed [CW-1:0] y_s1;
	side_t                side_q [1:ST_PRE-1];

	logic [LIM_W-1:0]     mx;
	logic [LIM_W-1:0]     my;
	logic [LIM_W-1:0]     mz;
	logic                 sat;
	logic [SQR_W-1:0]     sqx_s2;
	logic [SQR_W-1:0]     sqy_s2;
	logic [SQR_W-1:0]     sqz_s2;
	rot_t                 az_s2;
	logic [SQ_W-1:0]      sum_s3;

	rot_t                 az_chain [0:STEPS];
	sq_t                  sq_chain [0:RT_W];
	rot_t                 pol_chain [0:STEPS];

	logic signed [A_W-1:0]      gl;
	logic [GAIN_SH-1:0]         gl_lo;
	logic signed [A_W-GAIN_SH-1:0] gl_hi;
	logic signed [PH_W-1:0]     phi;
	logic [PL_W-1:0]            plo;
	logic signed [A_W-1:0]      phi_s21;
	logic [PL_W-1:0]            plo_s21;
	logic [PL_W:0]              plo_rnd;
	logic signed [A_W-1:0]      plen_s22;
	rot_t                       pol_s23;

	logic signed [ANG_W-1:0]    az_ang;
	logic signed [AZ_W-1:0]     az_val;
	logic [RT_W:0]              rad_rnd;
	logic [RAD_W-1:0]           rad_val;
	res_t                       res_q [ST_RES:ST_OUT-1];

	logic signed [ANG_W-1:0]    pol_ang;
	logic [POL_W-1:0]           pol_val;
	logic [OUT_W-1:0]           m_data_q;
	logic                       m_user_q;

	assign adv      = !vld_q[ST_OUT] || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_q[ST_OUT];
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

	assign in_x = s_tdata[CW-1:0];
	assign in_y = s_tdata[2*CW-1:CW];
	assign in_z = s_tdata[3*CW-1:2*CW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[ST_OUT-1:1], s_tvalid};
		end
	end

	// front end: magnitudes, squares and the azimuth quarter turn
	always_comb begin
		mx  = mag(x_s1);
		my  = mag(y_s1);
		mz  = mag(side_q[1].z);
		sat = (mx > LIM_W'(RADIUS_MAX)) || (my > LIM_W'(RADIUS_MAX)) ||
		      (mz > LIM_W'(RADIUS_MAX));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1      <= in_x;
			y_s1      <= in_y;
			side_q[1] <= '{z: in_z, zero: (in_x == '0) && (in_y == '0) && (in_z == '0),
			               xy0: (in_x == '0) && (in_y == '0), sat: 1'b0};
			side_q[2] <= '{z: side_q[1].z, zero: side_q[1].zero, xy0: side_q[1].xy0,
			               sat: sat};
			for (int k = 3; k < ST_PRE; k++) begin
				side_q[k] <= side_q[k-1];
			end
			sqx_s2 <= mx[MAG_W-1:0] * mx[MAG_W-1:0];
			sqy_s2 <= my[MAG_W-1:0] * my[MAG_W-1:0];
			sqz_s2 <= mz[MAG_W-1:0] * mz[MAG_W-1:0];
			az_s2  <= prerot(scale(x_s1), scale(y_s1));
			sum_s3 <= SQ_W'(sqx_s2) + SQ_W'(sqy_s2) + SQ_W'(sqz_s2);
		end
	end

	assign az_chain[0] = az_s2;
	assign sq_chain[0] = '{rem: sum_s3, root: '0};

	for (genvar i = 0; i < STEPS; i++) begin : g_az
		c2s_rot_cell u_cell (
			.clk     (clk),
			.en      (adv),
			.step    (STEP_W'(i)),
			.rot_in  (az_chain[i]),
			.rot_out (az_chain[i+1])
		);
	end

	for (genvar i = 0; i < RT_W; i++) begin : g_sqrt
		c2s_sqrt_cell u_cell (
			.clk    (clk),
			.en     (adv),
			.step   (RT_IDX_W'(RT_W - 1 - i)),
			.sq_in  (sq_chain[i]),
			.sq_out (sq_chain[i+1])
		);
	end

	// azimuth rounding, radius rounding, gain partial products
	always_comb begin
		gl    = az_chain[STEPS].a;
		gl_lo = gl[GAIN_SH-1:0];
		gl_hi = gl[A_W-1:GAIN_SH];
		phi   = gl_hi * $signed({1'b0, INV_GAIN_Q20});
		plo   = PL_W'(gl_lo) * PL_W'(INV_GAIN_Q20);

		az_ang = round_angle(az_chain[STEPS].acc);
		if (side_q[ST_AZ_END].xy0) begin
			az_val = '0;
		end else if (az_ang > ANGLE_MAX) begin
			az_val = ANGLE_MAX;
		end else if (az_ang < -ANGLE_MAX) begin
			az_val = -ANGLE_MAX;
		end else begin
			az_val = az_ang;
		end

		rad_rnd = (RT_W+1)'(sq_chain[RT_W].root) +
		          (RT_W+1)'(sq_chain[RT_W].rem > SQ_W'(sq_chain[RT_W].root));
		if (side_q[ST_AZ_END].sat || rad_rnd > (RT_W+1)'(RADIUS_MAX)) begin
			rad_val = RADIUS_MAX;
		end else begin
			rad_val = rad_rnd[RAD_W-1:0];
		end

		plo_rnd = (PL_W+1)'(plo_s21) + (PL_W+1)'(1 << (GAIN_SH - 1));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			phi_s21     <= A_W'(phi);
			plo_s21     <= plo;
			res_q[ST_RES] <= '{radius: rad_val, azimuth: az_val,
			                   zero: side_q[ST_AZ_END].zero};
			for (int k = ST_RES + 1; k < ST_OUT; k++) begin
				res_q[k] <= res_q[k-1];
			end
			if (side_q[ST_RES].xy0) begin
				plen_s22 <= '0;
			end else begin
				plen_s22 <= phi_s21 + A_W'(plo_rnd[PL_W:GAIN_SH]);
			end
			pol_s23 <= prerot(scale(side_q[ST_PRE-1].z), plen_s22);
		end
	end

	assign pol_chain[0] = pol_s23;

	for (genvar i = 0; i < STEPS; i++) begin : g_pol
		c2s_rot_cell u_cell (
			.clk     (clk),
			.en      (adv),
			.step    (STEP_W'(i)),
			.rot_in  (pol_chain[i]),
			.rot_out (pol_chain[i+1])
		);
	end

	// polar rounding and output register
	always_comb begin
		pol_ang = round_angle(pol_chain[STEPS].acc);
		if (res_q[ST_OUT-1].zero || pol_ang < 0) begin
			pol_val = '0;
		end else if (pol_ang > ANGLE_MAX) begin
			pol_val = ANGLE_MAX[POL_W-1:0];
		end else begin
			pol_val = pol_ang[POL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_data_q <= {{OUT_PAD{1'b0}}, res_q[ST_OUT-1].azimuth, pol_val,
			             res_q[ST_OUT-1].radius};
			m_user_q <= res_q[ST_OUT-1].zero;
		end
	end

endmodule

// File: hdl/c2s_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2s_checker
// Port-level checks of the converter output: stall behavior, the zero
// vector case, a nonzero radius for a nonzero point and the ranges of the angles.
// ----------------------------------------------------------------------------
module c2s_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [c2s_pkg::OUT_W-1:0] m_tdata,
	input logic                      m_tuser
);
	import c2s_pkg::*;

	logic [RAD_W-1:0]        radius;
	logic [POL_W-1:0]        polar;
	logic signed [AZ_W-1:0]  azimuth;

	assign radius  = m_tdata[RAD_W-1:0];
	assign polar   = m_tdata[RAD_W+POL_W-1:RAD_W];
	assign azimuth = m_tdata[RAD_W+POL_W+AZ_W-1:RAD_W+POL_W];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output request changed while stalled");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> radius == '0 && polar == '0 && azimuth == '0)
		else $error("zero vector with nonzero fields");

	a_radius: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> radius != '0)
		else $error("nonzero point with zero radius");

	a_polar: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> POL_W'(polar) <= ANGLE_MAX[POL_W-1:0])
		else $error("polar angle out of range");

	a_azimuth: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> azimuth <= ANGLE_MAX && azimuth >= -ANGLE_MAX)
		else $error("azimuth out of range");

endmodule

bind cartesian_to_spherical_core c2s_checker u_c2s_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream test of the Cartesian to spherical converter. Each point that is
// accepted goes through an integer model of the square root and of both
// vectoring rotations. The model's answer is queued and compared with the
// next result that leaves the core. Sender bursts and receiver stalls vary
// between phases.
// ----------------------------------------------------------------------------
module testbench;
	import c2s_pkg::*;

	localparam int      CLK_HALF    = 10;
	localparam int      LONG_HOLD   = 300;
	localparam int      DRAIN_LIMIT = 4000;
	localparam int      TAIL_CYCLES = 60;
	localparam longint  WORK_SCALE  = 64'sd1 << (WORK_BITS - COORD_WIDTH);
	localparam longint  QUARTER_DEG = 90 * 32768;
	localparam longint  GAIN_INV    = 636751;
	localparam longint  ANG_LIMIT   = 23040;
	localparam longint  RAD_LIMIT   = 65535;
	localparam longint  ATAN_DEG[18] = '{
		1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667, 7334,
		3667, 1833, 917, 458, 229, 115, 57, 29, 14
	};
	localparam logic signed [15:0] EDGE_VALS[6] = '{
		-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767
	};

	typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

	typedef struct packed {
		logic [RAD_W-1:0]        radius;
		logic [POL_W-1:0]        polar_angle;
		logic signed [AZ_W-1:0]  azimuth;
		logic                    zero_vector;
	} sph_t;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata  = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b1;
	logic [OUT_W-1:0]  m_tdata;
	logic              m_tuser;

	sph_t     spherical_due[$];
	int       errors     = 0;
	rx_mode_t rx_mode    = RX_ALWAYS;
	int       rx_stall   = 30;
	int       rx_tick    = 0;
	int       hold_left  = 0;
	bit       hold_req   = 1'b0;
	bit       tx_bursty  = 1'b0;
	int       burst_left = 0;

	cartesian_to_spherical_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #CLK_HALF clk = ~clk;

	// vectoring rotation: returns the angle in 2^-15 degree, len gets the scaled length
	function automatic longint cordic_angle(input longint a_in, input longint b_in,
		output longint len);
		longint a, b, acc, da, db, t;
		int     i;
		a   = a_in;
		b   = b_in;
		acc = 0;
		if (a < 0) begin
			t = a;
			if (b >= 0) begin
				a   = b;
				b   = -t;
				acc = QUARTER_DEG;
			end else begin
				a   = -b;
				b   = t;
				acc = -QUARTER_DEG;
			end
		end
		for (i = 0; i < 18; i++) begin
			da = b >>> i;
			db = a >>> i;
			if (b > 0) begin
				a   = a + da;
				b   = b - db;
				acc = acc + ATAN_DEG[i];
			end else begin
				a   = a - da;
				b   = b + db;
				acc = acc - ATAN_DEG[i];
			end
		end
		len = a;
		return acc;
	endfunction

	function automatic sph_t to_spherical(input logic signed [15:0] x, input logic signed [15:0] y,
		input logic signed [15:0] z);
		longint xv, yv, zv, ax, ay, az2, sq, root, cand, glen, plen, azi, pol;
		int     sh;
		sph_t   r;
		xv   = x;
		yv   = y;
		zv   = z;
		r    = '0;
		if (xv == 0 && yv == 0 && zv == 0) begin
			r.zero_vector = 1'b1;
			return r;
		end
		ax  = (xv < 0) ? -xv : xv;
		ay  = (yv < 0) ? -yv : yv;
		az2 = (zv < 0) ? -zv : zv;
		if (ax > RAD_LIMIT || ay > RAD_LIMIT || az2 > RAD_LIMIT) begin
			r.radius = '1;
		end else begin
			sq   = ax * ax + ay * ay + az2 * az2;
			root = 0;
			for (sh = 20; sh >= 0; sh--) begin
				cand = root | (64'sd1 << sh);
				if (cand * cand <= sq)
					root = cand;
			end
			if (sq - root * root > root)
				root = root + 1;
			r.radius = (root > RAD_LIMIT) ? '1 : root[RAD_W-1:0];
		end
		azi  = 0;
		plen = 0;
		if (xv != 0 || yv != 0) begin
			azi  = (cordic_angle(xv * WORK_SCALE, yv * WORK_SCALE, glen) + 128) >>> 8;
			azi  = (azi > ANG_LIMIT) ? ANG_LIMIT : ((azi < -ANG_LIMIT) ? -ANG_LIMIT : azi);
			plen = (glen * GAIN_INV + (64'sd1 << 19)) >>> 20;
		end
		pol = (cordic_angle(zv * WORK_SCALE, plen, glen) + 128) >>> 8;
		pol = (pol > ANG_LIMIT) ? ANG_LIMIT : ((pol < 0) ? 0 : pol);
		r.polar_angle = pol[POL_W-1:0];
		r.azimuth     = azi[AZ_W-1:0];
		return r;
	endfunction

	// receiver: long hold on request, otherwise stall by mode
	always @(posedge clk) begin
		rx_tick = rx_tick + 1;
		if (hold_req) begin
			hold_left = LONG_HOLD;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_ALWAYS:  m_tready <= 1'b1;
				RX_RANDOM:  m_tready <= ($urandom_range(99) >= rx_stall);
				RX_PATTERN: m_tready <= ((rx_tick % 11) > 3) && ((rx_tick % 5) != 0);
				default:    m_tready <= 1'b1;
			endcase
		end
	end

	always @(posedge clk) begin
		sph_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.radius      = m_tdata[RAD_W-1:0];
			got.polar_angle = m_tdata[RAD_W +: POL_W];
			got.azimuth     = m_tdata[RAD_W+POL_W +: AZ_W];
			got.zero_vector = m_tuser;
			if (spherical_due.size() == 0) begin
				errors = errors + 1;
				$display("%0t unexpected result: expected none actual %h", $time, got);
			end else begin
				want = spherical_due.pop_front();
				if (got.radius !== want.radius) begin
					errors = errors + 1;
					$display("%0t radius mismatch: expected %0d actual %0d",
						$time, want.radius, got.radius);
				end
				if (got.polar_angle !== want.polar_angle) begin
					errors = errors + 1;
					$display("%0t polar_angle mismatch: expected %0d actual %0d",
						$time, want.polar_angle, got.polar_angle);
				end
				if (got.azimuth !== want.azimuth) begin
					errors = errors + 1;
					$display("%0t azimuth mismatch: expected %0d actual %0d",
						$time, want.azimuth, got.azimuth);
				end
				if (got.zero_vector !== want.zero_vector) begin
					errors = errors + 1;
					$display("%0t zero_vector mismatch: expected %0d actual %0d",
						$time, want.zero_vector, got.zero_vector);
				end
			end
		end
	end

	// call only right after a rising edge; returns at the edge that accepts, or after the pause that ends a burst
	task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
		input logic signed [15:0] z);
		s_tdata  <= {z, y, x};
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		spherical_due.push_back(to_spherical(x, y, z));
		if (tx_bursty) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(24, 1);
				s_tvalid <= 1'b0;
				repeat ($urandom_range(8, 1)) @(posedge clk);
			end else begin
				burst_left = burst_left - 1;
			end
		end
	endtask

	task automatic stop_sending();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		int n;
		n = 0;
		while (spherical_due.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n = n + 1;
		end
	endtask

	task automatic random_point(output logic signed [15:0] x, output logic signed [15:0] y,
		output logic signed [15:0] z);
		int v[3];
		int k;
		case ($urandom_range(9))
			4: begin
				for (k = 0; k < 3; k++)
					v[k] = int'($urandom_range(8)) - 4;
			end
			5: begin
				v = '{0, 0, 0};
				v[$urandom_range(2)] = int'($urandom_range(65535)) - 32768;
			end
			6: begin
				for (k = 0; k < 3; k++)
					v[k] = EDGE_VALS[$urandom_range(5)];
			end
			7: begin
				for (k = 0; k < 3; k++)
					v[k] = int'($urandom_range(65535)) - 32768;
				v[$urandom_range(2)] = 0;
			end
			8: begin
				for (k = 0; k < 3; k++)
					v[k] = $urandom_range(1) ? int'($urandom_range(32767, 30000))
						: -int'($urandom_range(32768, 30000));
			end
			9: begin
				v[0] = int'($urandom_range(6)) - 3;
				v[1] = int'($urandom_range(6)) - 3;
				v[2] = int'($urandom_range(65535)) - 32768;
			end
			default: begin
				for (k = 0; k < 3; k++)
					v[k] = int'($urandom_range(65535)) - 32768;
			end
		endcase
		x = v[0][15:0];
		y = v[1][15:0];
		z = v[2][15:0];
	endtask

	task automatic test_special_points();
		rx_mode   = RX_ALWAYS;
		tx_bursty = 1'b0;
		send_point(0, 0, 0);
		send_point(0, 0, 1);
		send_point(0, 0, -1);
		send_point(0, 0, 32767);
		send_point(0, 0, -32768);
		send_point(-32768, -32768, -32768);
		send_point(32767, 32767, 32767);
		send_point(-32768, 32767, 0);
		send_point(32767, -32768, -32768);
		send_point(-1, 0, 0);
		send_point(-32768, 0, 0);
		send_point(0, -32768, 0);
		send_point(0, 32767, 0);
		send_point(1, 0, 0);
		send_point(0, 1, 0);
		send_point(-1, -1, 5);
		send_point(-1, 1, -5);
		send_point(1, -1, 0);
		send_point(1, 1, 1);
		send_point(-32768, -1, 1);
		send_point(3, 4, 12);
		send_point(-20000, 15000, -32768);
		stop_sending();
		wait_drained();
	endtask

	task automatic test_random_stream(input int count);
		logic signed [15:0] x, y, z;
		int i;
		for (i = 0; i < count; i++) begin
			if (i % 250 == 0) begin
				case ((i / 250) % 4)
					0: begin rx_mode = RX_RANDOM;  rx_stall = 30; tx_bursty = 1'b1; end
					1: begin rx_mode = RX_ALWAYS;  tx_bursty = 1'b0; end
					2: begin rx_mode = RX_PATTERN; tx_bursty = 1'b1; end
					default: begin rx_mode = RX_RANDOM; rx_stall = 70; tx_bursty = 1'b0; end
				endcase
			end
			random_point(x, y, z);
			send_point(x, y, z);
		end
		stop_sending();
		wait_drained();
	endtask

	task automatic test_output_hold();
		logic signed [15:0] x, y, z;
		int i;
		rx_mode   = RX_ALWAYS;
		tx_bursty = 1'b0;
		@(negedge clk);
		hold_req = 1'b1;
		@(posedge clk);
		for (i = 0; i < 90; i++) begin
			random_point(x, y, z);
			send_point(x, y, z);
		end
		stop_sending();
		wait_drained();
	endtask

	task automatic test_drain_pause();
		logic signed [15:0] x, y, z;
		int i;
		rx_mode   = RX_RANDOM;
		rx_stall  = 40;
		tx_bursty = 1'b1;
		for (i = 0; i < 60; i++) begin
			if (i == 30) begin
				stop_sending();
				wait_drained();
			end
			random_point(x, y, z);
			send_point(x, y, z);
		end
		stop_sending();
		wait_drained();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_points();
		test_random_stream(1400);
		test_output_hold();
		test_drain_pause();
		if (spherical_due.size() != 0) begin
			errors = errors + 1;
			$display("%0t missing results: expected %0d more actual 0",
				$time, spherical_due.size());
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
